// File: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test package
// Shared types, register indexes, reset values and operation codes.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int MAX_EDGES_DEF = 256;

   localparam int MARGIN_W = 31;
   localparam int TOL_W    = 31;
   localparam int DIST_W   = 63;
   localparam int CSR_W    = 63;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RAY_MARGIN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_TOLERANCE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_DIST_SQ    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLLINEAR_LIMIT = 2'd3;

   localparam logic [MARGIN_W-1:0] RAY_MARGIN_RST      = 31'd655360;
   localparam logic [TOL_W-1:0]    BOX_TOLERANCE_RST   = 31'd1;
   localparam logic [DIST_W-1:0]   NEAR_DIST_SQ_RST    = 63'd1;
   localparam logic [DIST_W-1:0]   COLLINEAR_LIMIT_RST = 63'd1;

   // transaction functions
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   // per-edge operations of the shared multiplier
   localparam int NUM_OPS = 13;
   localparam logic [3:0] OP_NEAR_PS  = 4'd0;
   localparam logic [3:0] OP_NEAR_PE  = 4'd1;
   localparam logic [3:0] OP_COL_P    = 4'd2;
   localparam logic [3:0] OP_S1       = 4'd3;
   localparam logic [3:0] OP_S2       = 4'd4;
   localparam logic [3:0] OP_S3       = 4'd5;
   localparam logic [3:0] OP_S4       = 4'd6;
   localparam logic [3:0] OP_NEAR_SR  = 4'd7;
   localparam logic [3:0] OP_NEAR_SP  = 4'd8;
   localparam logic [3:0] OP_COL_S    = 4'd9;
   localparam logic [3:0] OP_NEAR_ER  = 4'd10;
   localparam logic [3:0] OP_NEAR_EP  = 4'd11;
   localparam logic [3:0] OP_COL_E    = 4'd12;

   localparam logic [1:0] KIND_NEAR = 2'd0;
   localparam logic [1:0] KIND_COL  = 2'd1;
   localparam logic [1:0] KIND_SIGN = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] coord_a_x;
      logic signed [31:0] coord_a_y;
      logic signed [31:0] coord_b_x;
      logic signed [31:0] coord_b_y;
   } req_type;

   typedef struct packed {
      logic               inside_res;
      logic               on_edge;
      logic [7:0]         edge_index;
      logic signed [31:0] edge_start_x;
      logic signed [31:0] edge_start_y;
      logic signed [31:0] edge_end_x;
      logic signed [31:0] edge_end_y;
      logic               store_overflowed;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
   } edge_type;

   typedef struct packed {
      logic signed [32:0] x1;
      logic signed [32:0] y1;
      logic signed [32:0] x2;
      logic signed [32:0] y2;
      logic [1:0]         kind;
   } opnd_type;

   function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      sub33 = $signed({a[31], a}) - $signed({b[31], b});
   endfunction

endpackage

// File: rtl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Edge store with clear, append and ray-casting point query.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  handshake
//  request   start, busy, req_data          in         start & !busy
//  response  rsp_valid, rsp_data            out        one-cycle strobe
//  csr       csr_we, csr_index, csr_data    in         write on csr_we
//
//  Clear, append and unused functions finish in the accepting cycle.
//  A query scans the N stored edges for the least x (a read and a compare
//  state per edge), sets the ray start in a margin state, then tests each
//  edge up to the first one holding the point: one read, 13 multiply pairs
//  on the single 33x33 multiplier, and one decision state.
//  Reset is synchronous; it empties the store and restores register values.
//  The response cannot be stalled; busy drops in the cycle it is shown.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
   parameter int MAX_EDGES = pip_pkg::MAX_EDGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  pip_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output pip_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [pip_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pip_pkg::CSR_W-1:0]       csr_data
);

   localparam int AW = $clog2(MAX_EDGES);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EDGES);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MIN_RD  = 4'd1;
   localparam logic [3:0] S_MIN_ACC = 4'd2;
   localparam logic [3:0] S_MARGIN  = 4'd3;
   localparam logic [3:0] S_T_RD    = 4'd4;
   localparam logic [3:0] S_MUL0    = 4'd5;
   localparam logic [3:0] S_MUL1    = 4'd6;
   localparam logic [3:0] S_EVAL    = 4'd7;
   localparam logic [3:0] S_T_DONE  = 4'd8;

   logic [3:0]                      state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic                            ovf_ff, ovf_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic [3:0]                      op_ff, op_in;
   logic                            hits_ff, hits_in;
   logic signed [31:0]              px_ff, px_in, py_ff, py_in;
   logic signed [31:0]              xmin_ff, xmin_in;
   logic signed [31:0]              xm_ff, xm_in;
   logic signed [65:0]              prod_ff, prod_in, first_ff, first_in;
   logic [pip_pkg::NUM_OPS-1:0]     flag_ff, flag_in, neg_ff, neg_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pip_pkg::rsp_type                rsp_ff, rsp_in;

   logic [pip_pkg::MARGIN_W-1:0]    margin_ff;
   logic [pip_pkg::TOL_W-1:0]       tol_ff;
   logic [pip_pkg::DIST_W-1:0]      near_ff, lim_ff;

   pip_pkg::edge_type               mem [MAX_EDGES];
   pip_pkg::edge_type               rd_ff;
   logic                            rd_en, wr_en;
   pip_pkg::edge_type               wr_data;

   pip_pkg::opnd_type               opnd;
   logic signed [32:0]              mul_x, mul_y;
   logic signed [66:0]              res, res_abs;
   logic signed [32:0]              mdiff;
   logic                            last_edge;
   logic                            on_p, on_s, on_e, box_ok, meet;
   logic                            s1p, s1n, s2p, s2n, s3p, s3n, s4p, s4n;
   logic signed [31:0]              lo_x, hi_x, lo_y, hi_y;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= pip_pkg::RAY_MARGIN_RST;
         tol_ff    <= pip_pkg::BOX_TOLERANCE_RST;
         near_ff   <= pip_pkg::NEAR_DIST_SQ_RST;
         lim_ff    <= pip_pkg::COLLINEAR_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            pip_pkg::CSR_RAY_MARGIN:      margin_ff <= csr_data[pip_pkg::MARGIN_W-1:0];
            pip_pkg::CSR_BOX_TOLERANCE:   tol_ff    <= csr_data[pip_pkg::TOL_W-1:0];
            pip_pkg::CSR_NEAR_DIST_SQ:    near_ff   <= csr_data[pip_pkg::DIST_W-1:0];
            pip_pkg::CSR_COLLINEAR_LIMIT: lim_ff    <= csr_data[pip_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // edge store
   assign wr_en = (state_ff == S_IDLE) && start && (req_data.func == pip_pkg::FUNC_APPEND)
                  && (count_ff < MAX_CNT);
   assign wr_data = '{sx: req_data.coord_a_x, sy: req_data.coord_a_y,
                      ex: req_data.coord_b_x, ey: req_data.coord_b_y};
   assign rd_en = (state_ff == S_MIN_RD) || (state_ff == S_T_RD);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      opnd = '0;
      case (op_ff)
         pip_pkg::OP_NEAR_PS: begin
            opnd.x1 = pip_pkg::sub33(px_ff, rd_ff.sx); opnd.y1 = opnd.x1;
            opnd.x2 = pip_pkg::sub33(py_ff, rd_ff.sy); opnd.y2 = opnd.x2;
            opnd.kind = pip_pkg::KIND_NEAR;
         end
         pip_pkg::OP_NEAR_PE: begin
            opnd.x1 = pip_pkg::sub33(px_ff, rd_ff.ex); opnd.y1 = opnd.x1;
            opnd.x2 = pip_pkg::sub33(py_ff, rd_ff.ey); opnd.y2 = opnd.x2;
            opnd.kind = pip_pkg::KIND_NEAR;
         end
         pip_pkg::OP_COL_P: begin
            opnd.x1 = pip_pkg::sub33(px_ff, rd_ff.sx);
            opnd.y1 = pip_pkg::sub33(py_ff, rd_ff.ey);
            opnd.x2 = pip_pkg::sub33(py_ff, rd_ff.sy);
            opnd.y2 = pip_pkg::sub33(px_ff, rd_ff.ex);
            opnd.kind = pip_pkg::KIND_COL;
         end
         pip_pkg::OP_S1: begin
            opnd.x1 = pip_pkg::sub33(rd_ff.sx, xm_ff);
            opnd.y1 = pip_pkg::sub33(rd_ff.ey, py_ff);
            opnd.x2 = pip_pkg::sub33(rd_ff.sy, py_ff);
            opnd.y2 = pip_pkg::sub33(rd_ff.ex, xm_ff);
            opnd.kind = pip_pkg::KIND_SIGN;
         end
         pip_pkg::OP_S2: begin
            opnd.x1 = pip_pkg::sub33(rd_ff.sx, px_ff);
            opnd.y1 = pip_pkg::sub33(rd_ff.ey, py_ff);
            opnd.x2 = pip_pkg::sub33(rd_ff.sy, py_ff);
            opnd.y2 = pip_pkg::sub33(rd_ff.ex, px_ff);
            opnd.kind = pip_pkg::KIND_SIGN;
         end
         pip_pkg::OP_S3: begin
            opnd.x1 = pip_pkg::sub33(xm_ff, rd_ff.sx);
            opnd.y1 = pip_pkg::sub33(py_ff, rd_ff.sy);
            opnd.x2 = opnd.y1;
            opnd.y2 = pip_pkg::sub33(px_ff, rd_ff.sx);
            opnd.kind = pip_pkg::KIND_SIGN;
         end
         pip_pkg::OP_S4: begin
            opnd.x1 = pip_pkg::sub33(xm_ff, rd_ff.ex);
            opnd.y1 = pip_pkg::sub33(py_ff, rd_ff.ey);
            opnd.x2 = opnd.y1;
            opnd.y2 = pip_pkg::sub33(px_ff, rd_ff.ex);
            opnd.kind = pip_pkg::KIND_SIGN;
         end
         pip_pkg::OP_NEAR_SR: begin
            opnd.x1 = pip_pkg::sub33(rd_ff.sx, xm_ff); opnd.y1 = opnd.x1;
            opnd.x2 = pip_pkg::sub33(rd_ff.sy, py_ff); opnd.y2 = opnd.x2;
            opnd.kind = pip_pkg::KIND_NEAR;
         end
         pip_pkg::OP_NEAR_SP: begin
            opnd.x1 = pip_pkg::sub33(rd_ff.sx, px_ff); opnd.y1 = opnd.x1;
            opnd.x2 = pip_pkg::sub33(rd_ff.sy, py_ff); opnd.y2 = opnd.x2;
            opnd.kind = pip_pkg::KIND_NEAR;
         end
         pip_pkg::OP_COL_S: begin
            opnd.x1 = pip_pkg::sub33(rd_ff.sx, xm_ff);
            opnd.y1 = pip_pkg::sub33(rd_ff.sy, py_ff);
            opnd.x2 = opnd.y1;
            opnd.y2 = pip_pkg::sub33(rd_ff.sx, px_ff);
            opnd.kind = pip_pkg::KIND_COL;
         end
         pip_pkg::OP_NEAR_ER: begin
            opnd.x1 = pip_pkg::sub33(rd_ff.ex, xm_ff); opnd.y1 = opnd.x1;
            opnd.x2 = pip_pkg::sub33(rd_ff.ey, py_ff); opnd.y2 = opnd.x2;
            opnd.kind = pip_pkg::KIND_NEAR;
         end
         pip_pkg::OP_NEAR_EP: begin
            opnd.x1 = pip_pkg::sub33(rd_ff.ex, px_ff); opnd.y1 = opnd.x1;
            opnd.x2 = pip_pkg::sub33(rd_ff.ey, py_ff); opnd.y2 = opnd.x2;
            opnd.kind = pip_pkg::KIND_NEAR;
         end
         pip_pkg::OP_COL_E: begin
            opnd.x1 = pip_pkg::sub33(rd_ff.ex, xm_ff);
            opnd.y1 = pip_pkg::sub33(rd_ff.ey, py_ff);
            opnd.x2 = opnd.y1;
            opnd.y2 = pip_pkg::sub33(rd_ff.ex, px_ff);
            opnd.kind = pip_pkg::KIND_COL;
         end
         default: opnd = '0;
      endcase
   end

   assign mul_x = (state_ff == S_MUL0) ? opnd.x1 : opnd.x2;
   assign mul_y = (state_ff == S_MUL0) ? opnd.y1 : opnd.y2;

   // squared distance adds, cross products subtract
   assign res = (opnd.kind == pip_pkg::KIND_NEAR) ?
                $signed({first_ff[65], first_ff}) + $signed({prod_ff[65], prod_ff}) :
                $signed({first_ff[65], first_ff}) - $signed({prod_ff[65], prod_ff});
   assign res_abs = res[66] ? -res : res;

   // per-edge decision
   assign lo_x = (rd_ff.sx < rd_ff.ex) ? rd_ff.sx : rd_ff.ex;
   assign hi_x = (rd_ff.sx > rd_ff.ex) ? rd_ff.sx : rd_ff.ex;
   assign lo_y = (rd_ff.sy < rd_ff.ey) ? rd_ff.sy : rd_ff.ey;
   assign hi_y = (rd_ff.sy > rd_ff.ey) ? rd_ff.sy : rd_ff.ey;

   assign on_p = flag_ff[pip_pkg::OP_NEAR_PS] || flag_ff[pip_pkg::OP_NEAR_PE] ||
                 (flag_ff[pip_pkg::OP_COL_P] && px_ff >= lo_x && px_ff <= hi_x &&
                  py_ff >= lo_y && py_ff <= hi_y);
   // the ray box spans xm..px on the line y = py
   assign on_s = flag_ff[pip_pkg::OP_NEAR_SR] || flag_ff[pip_pkg::OP_NEAR_SP] ||
                 (flag_ff[pip_pkg::OP_COL_S] && rd_ff.sx >= xm_ff && rd_ff.sx <= px_ff &&
                  rd_ff.sy == py_ff);
   assign on_e = flag_ff[pip_pkg::OP_NEAR_ER] || flag_ff[pip_pkg::OP_NEAR_EP] ||
                 (flag_ff[pip_pkg::OP_COL_E] && rd_ff.ex >= xm_ff && rd_ff.ex <= px_ff &&
                  rd_ff.ey == py_ff);

   assign box_ok = !(pip_pkg::sub33(lo_x, px_ff) > $signed({2'b00, tol_ff})) &&
                   !(pip_pkg::sub33(xm_ff, hi_x) > $signed({2'b00, tol_ff})) &&
                   !(pip_pkg::sub33(lo_y, py_ff) > $signed({2'b00, tol_ff})) &&
                   !(pip_pkg::sub33(py_ff, hi_y) > $signed({2'b00, tol_ff}));

   assign s1n = neg_ff[pip_pkg::OP_S1];
   assign s1p = flag_ff[pip_pkg::OP_S1] && !s1n;
   assign s2n = neg_ff[pip_pkg::OP_S2];
   assign s2p = flag_ff[pip_pkg::OP_S2] && !s2n;
   assign s3n = neg_ff[pip_pkg::OP_S3];
   assign s3p = flag_ff[pip_pkg::OP_S3] && !s3n;
   assign s4n = neg_ff[pip_pkg::OP_S4];
   assign s4p = flag_ff[pip_pkg::OP_S4] && !s4n;

   assign meet = box_ok && !((s1p && s2p) || (s1n && s2n)) &&
                 !((s3p && s4p) || (s3n && s4n));

   assign last_edge = ((idx_ff + 1'b1) == count_ff);
   assign mdiff = $signed({xmin_ff[31], xmin_ff}) - $signed({2'b00, margin_ff});

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      hits_in      = hits_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      xmin_in      = xmin_ff;
      xm_in        = xm_ff;
      prod_in      = prod_ff;
      first_in     = first_ff;
      flag_in      = flag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.func)
                  pip_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  pip_pkg::FUNC_APPEND: begin
                     if (count_ff < MAX_CNT) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  pip_pkg::FUNC_QUERY: begin
                     px_in   = req_data.coord_a_x;
                     py_in   = req_data.coord_a_y;
                     xmin_in = req_data.coord_a_x;
                     idx_in  = '0;
                     hits_in = 1'b0;
                     state_in = (count_ff == '0) ? S_MARGIN : S_MIN_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_MIN_RD: begin
            state_in = S_MIN_ACC;
         end
         S_MIN_ACC: begin
            if (rd_ff.sx < xmin_ff) begin
               xmin_in = rd_ff.sx;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = last_edge ? S_MARGIN : S_MIN_RD;
         end
         S_MARGIN: begin
            // saturate the ray start at the most negative coordinate
            xm_in  = (mdiff[32] != mdiff[31]) ? 32'sh8000_0000 : mdiff[31:0];
            idx_in = '0;
            if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.store_overflowed = ovf_ff;
               state_in = S_IDLE;
            end else begin
               state_in = S_T_RD;
            end
         end
         S_T_RD: begin
            op_in    = pip_pkg::OP_NEAR_PS;
            state_in = S_MUL0;
         end
         S_MUL0: begin
            prod_in  = mul_x * mul_y;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            first_in = prod_ff;
            prod_in  = mul_x * mul_y;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (opnd.kind)
               pip_pkg::KIND_NEAR: flag_in[op_ff] = (res < $signed({4'b0000, near_ff}));
               pip_pkg::KIND_COL:  flag_in[op_ff] = (res_abs < $signed({4'b0000, lim_ff}));
               default:            flag_in[op_ff] = (res != '0);
            endcase
            neg_in[op_ff] = res[66];
            if (op_ff == pip_pkg::OP_COL_E) begin
               state_in = S_T_DONE;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = S_MUL0;
            end
         end
         S_T_DONE: begin
            if (on_p) begin
               rsp_valid_in = 1'b1;
               rsp_in.inside_res       = 1'b0;
               rsp_in.on_edge          = 1'b1;
               rsp_in.edge_index       = 8'(idx_ff);
               rsp_in.edge_start_x     = rd_ff.sx;
               rsp_in.edge_start_y     = rd_ff.sy;
               rsp_in.edge_end_x       = rd_ff.ex;
               rsp_in.edge_end_y       = rd_ff.ey;
               rsp_in.store_overflowed = ovf_ff;
               state_in = S_IDLE;
            end else begin
               // count a crossing unless the edge lies on the ray
               if (meet && !(on_s && on_e)) begin
                  hits_in = !hits_ff;
               end
               idx_in = idx_ff + 1'b1;
               if (last_edge) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '0;
                  rsp_in.inside_res = hits_ff ^ (meet && !(on_s && on_e));
                  rsp_in.store_overflowed = ovf_ff;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_T_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         op_ff        <= '0;
         hits_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         op_ff        <= op_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      xmin_ff  <= xmin_in;
      xm_ff    <= xm_in;
      prod_ff  <= prod_in;
      first_ff <= first_in;
      flag_ff  <= flag_in;
      neg_ff   <= neg_in;
      rsp_ff   <= rsp_in;
   end

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) != S_IDLE)
      else $error("response without a query in progress");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while still busy");

   a_on_edge_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.on_edge |-> !rsp_data.inside_res)
      else $error("point on an edge reported inside");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("edge count beyond store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == MAX_CNT)
      else $error("overflow flagged with room left");

endmodule

// File: bench/point_in_polygon_test_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-in-polygon checker
// Watches the request, response and register channels of the block, keeps
// its own edge store and register copies, works out the answer of every
// accepted query and compares each response field by field.
// ----------------------------------------------------------------------------
module point_in_polygon_test_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  pip_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  pip_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [pip_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pip_pkg::CSR_W-1:0]     csr_data,
   output int                            fail_count,
   output int                            answers_due,
   output int                            answers_seen
);

   localparam int STORE_DEPTH = pip_pkg::MAX_EDGES_DEF;

   logic signed [31:0] store_sx [STORE_DEPTH];
   logic signed [31:0] store_sy [STORE_DEPTH];
   logic signed [31:0] store_ex [STORE_DEPTH];
   logic signed [31:0] store_ey [STORE_DEPTH];
   int                 stored_edges;
   logic               dropped_append;

   logic [pip_pkg::MARGIN_W-1:0] margin;
   logic [pip_pkg::TOL_W-1:0]    tolerance;
   logic [pip_pkg::DIST_W-1:0]   near_limit;
   logic [pip_pkg::DIST_W-1:0]   col_limit;

   pip_pkg::rsp_type answer_q [$];

   initial begin
      fail_count = 0;
      answers_due = 0;
      answers_seen = 0;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("%t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic logic signed [127:0] cross_z(input longint ax, input longint ay,
                                                   input longint bx, input longint by);
      logic signed [127:0] wax, way, wbx, wby;
      wax = ax;
      way = ay;
      wbx = bx;
      wby = by;
      return wax * wby - way * wbx;
   endfunction

   function automatic int sign_of(input logic signed [127:0] v);
      return (v < 0) ? -1 : ((v != 0) ? 1 : 0);
   endfunction

   function automatic longint min2(input longint a, input longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint max2(input longint a, input longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic bit is_near(input longint px, input longint py,
                                  input longint qx, input longint qy);
      longint      dx, dy;
      logic [63:0] ux, uy, sqx, sqy;
      logic [64:0] total;
      dx = px - qx;
      dy = py - qy;
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      if (ux >= 64'h1_0000_0000 || uy >= 64'h1_0000_0000) return 0;
      sqx = ux * ux;
      sqy = uy * uy;
      total = {1'b0, sqx} + {1'b0, sqy};
      if (total[64]) return 0;
      return total[63:0] < {1'b0, near_limit};
   endfunction

   function automatic bit on_line(input longint px, input longint py,
                                  input longint ax, input longint ay,
                                  input longint bx, input longint by);
      logic signed [127:0] c, lim;
      if (is_near(px, py, ax, ay) || is_near(px, py, bx, by)) return 1;
      c = cross_z(px - ax, py - ay, px - bx, py - by);
      if (c < 0) c = -c;
      lim = {65'd0, col_limit};
      if (!(c < lim)) return 0;
      return px >= min2(ax, bx) && px <= max2(ax, bx) &&
             py >= min2(ay, by) && py <= max2(ay, by);
   endfunction

   function automatic bit crosses(input longint p1x, input longint p1y,
                                  input longint p2x, input longint p2y,
                                  input longint q1x, input longint q1y,
                                  input longint q2x, input longint q2y);
      longint tol;
      int     s1, s2, s3, s4;
      tol = longint'({33'd0, tolerance});
      if (min2(q1x, q2x) - max2(p1x, p2x) > tol ||
          min2(p1x, p2x) - max2(q1x, q2x) > tol ||
          min2(q1y, q2y) - max2(p1y, p2y) > tol ||
          min2(p1y, p2y) - max2(q1y, q2y) > tol) return 0;
      s1 = sign_of(cross_z(q1x - p1x, q1y - p1y, q2x - p1x, q2y - p1y));
      s2 = sign_of(cross_z(q1x - p2x, q1y - p2y, q2x - p2x, q2y - p2y));
      s3 = sign_of(cross_z(p1x - q1x, p1y - q1y, p2x - q1x, p2y - q1y));
      s4 = sign_of(cross_z(p1x - q2x, p1y - q2y, p2x - q2x, p2y - q2y));
      return s1 * s2 <= 0 && s3 * s4 <= 0;
   endfunction

   function automatic pip_pkg::rsp_type locate_point(input pip_pkg::req_type q);
      pip_pkg::rsp_type r;
      longint  px, py, ray_x, sx, sy, ex, ey;
      int      hits;
      bit      found;
      int      at;
      px = q.coord_a_x;
      py = q.coord_a_y;
      hits = 0;
      found = 0;
      at = 0;
      ray_x = px;
      for (int i = 0; i < stored_edges; i++)
         if (store_sx[i] < ray_x) ray_x = store_sx[i];
      ray_x = ray_x - longint'({33'd0, margin});
      if (ray_x < -64'sd2147483648) ray_x = -64'sd2147483648;
      for (int i = 0; i < stored_edges && !found; i++) begin
         sx = store_sx[i];
         sy = store_sy[i];
         ex = store_ex[i];
         ey = store_ey[i];
         if (on_line(px, py, sx, sy, ex, ey)) begin
            found = 1;
            at = i;
         end else if (crosses(ray_x, py, px, py, sx, sy, ex, ey) &&
                      !(on_line(sx, sy, ray_x, py, px, py) &&
                        on_line(ex, ey, ray_x, py, px, py))) begin
            hits++;
         end
      end
      r = '0;
      if (found) begin
         r.on_edge = 1'b1;
         r.edge_index = at[7:0];
         r.edge_start_x = store_sx[at];
         r.edge_start_y = store_sy[at];
         r.edge_end_x = store_ex[at];
         r.edge_end_y = store_ey[at];
      end else begin
         r.inside_res = hits[0];
      end
      r.store_overflowed = dropped_append;
      return r;
   endfunction

   always @(posedge clock) begin
      pip_pkg::rsp_type want;
      if (reset) begin
         stored_edges = 0;
         dropped_append = 1'b0;
         margin = pip_pkg::RAY_MARGIN_RST;
         tolerance = pip_pkg::BOX_TOLERANCE_RST;
         near_limit = pip_pkg::NEAR_DIST_SQ_RST;
         col_limit = pip_pkg::COLLINEAR_LIMIT_RST;
         answer_q.delete();
      end else begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               report("unexpected response", 1, 0);
            end else begin
               want = answer_q.pop_front();
               answers_seen++;
               if (rsp_data.inside_res !== want.inside_res)
                  report("inside_res", rsp_data.inside_res, want.inside_res);
               if (rsp_data.on_edge !== want.on_edge)
                  report("on_edge", rsp_data.on_edge, want.on_edge);
               if (rsp_data.edge_index !== want.edge_index)
                  report("edge_index", rsp_data.edge_index, want.edge_index);
               if (rsp_data.edge_start_x !== want.edge_start_x)
                  report("edge_start_x", rsp_data.edge_start_x, want.edge_start_x);
               if (rsp_data.edge_start_y !== want.edge_start_y)
                  report("edge_start_y", rsp_data.edge_start_y, want.edge_start_y);
               if (rsp_data.edge_end_x !== want.edge_end_x)
                  report("edge_end_x", rsp_data.edge_end_x, want.edge_end_x);
               if (rsp_data.edge_end_y !== want.edge_end_y)
                  report("edge_end_y", rsp_data.edge_end_y, want.edge_end_y);
               if (rsp_data.store_overflowed !== want.store_overflowed)
                  report("store_overflowed", rsp_data.store_overflowed,
                         want.store_overflowed);
            end
         end
         if (csr_we) begin
            case (csr_index)
               pip_pkg::CSR_RAY_MARGIN:      margin = csr_data[pip_pkg::MARGIN_W-1:0];
               pip_pkg::CSR_BOX_TOLERANCE:   tolerance = csr_data[pip_pkg::TOL_W-1:0];
               pip_pkg::CSR_NEAR_DIST_SQ:    near_limit = csr_data[pip_pkg::DIST_W-1:0];
               pip_pkg::CSR_COLLINEAR_LIMIT: col_limit = csr_data[pip_pkg::DIST_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (req_data.func)
               pip_pkg::FUNC_CLEAR: begin
                  stored_edges = 0;
                  dropped_append = 1'b0;
               end
               pip_pkg::FUNC_APPEND: begin
                  if (stored_edges >= STORE_DEPTH) begin
                     dropped_append = 1'b1;
                  end else begin
                     store_sx[stored_edges] = req_data.coord_a_x;
                     store_sy[stored_edges] = req_data.coord_a_y;
                     store_ex[stored_edges] = req_data.coord_b_x;
                     store_ey[stored_edges] = req_data.coord_b_y;
                     stored_edges++;
                  end
               end
               pip_pkg::FUNC_QUERY: answer_q = {answer_q, locate_point(req_data)};
               default: ;
            endcase
         end
      end
      answers_due = answer_q.size();
   end

endmodule

// File: bench/point_in_polygon_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-in-polygon test bench
// Drives directed and random clear, append, query and unused-function
// transactions through several register settings with random start gaps;
// the checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;

   localparam int  CYCLE_LIMIT  = 30000000;
   localparam int  PHASE_ITEMS  = 55;
   localparam int  ONE          = 65536;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   pip_pkg::req_type              req_data;
   logic                          rsp_valid;
   pip_pkg::rsp_type              rsp_data;
   logic                          csr_we;
   logic [pip_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pip_pkg::CSR_W-1:0]     csr_data;

   int  fail_count, answers_due, answers_seen;
   int  cycles;
   int  items_sent;
   int  queries_sent;
   bit  calm;

   logic signed [31:0] poly_x [$];
   logic signed [31:0] poly_y [$];

   point_in_polygon_test uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   point_in_polygon_test_checker check_unit (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .answers_due(answers_due),
      .answers_seen(answers_seen)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** point_in_polygon_test: FAILED **");
         $finish;
      end
   end

   task automatic send(input logic [1:0] f, input logic signed [31:0] ax,
                       input logic signed [31:0] ay, input logic signed [31:0] bx,
                       input logic signed [31:0] by);
      pip_pkg::req_type r;
      r.func = f;
      r.coord_a_x = ax;
      r.coord_a_y = ay;
      r.coord_b_x = bx;
      r.coord_b_y = by;
      // random hold-off before the transaction
      if (!calm && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      items_sent++;
      if (f == pip_pkg::FUNC_QUERY) queries_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (answers_due != 0 || busy);
      @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_regs(input logic [pip_pkg::CSR_W-1:0] m,
                           input logic [pip_pkg::CSR_W-1:0] t,
                           input logic [pip_pkg::CSR_W-1:0] n,
                           input logic [pip_pkg::CSR_W-1:0] c);
      csr_we <= 1'b1;
      csr_index <= pip_pkg::CSR_RAY_MARGIN;
      csr_data <= m;
      @(posedge clock);
      csr_index <= pip_pkg::CSR_BOX_TOLERANCE;
      csr_data <= t;
      @(posedge clock);
      csr_index <= pip_pkg::CSR_NEAR_DIST_SQ;
      csr_data <= n;
      @(posedge clock);
      csr_index <= pip_pkg::CSR_COLLINEAR_LIMIT;
      csr_data <= c;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rnd_coord();
      int v;
      v = 0;
      case ($urandom_range(0, 9))
         0: v = $urandom;
         1: v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         2, 3: v = ($urandom_range(0, 40) - 20) * ONE;
         default: v = $urandom_range(0, 40 * ONE) - 20 * ONE;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] pick_point_x(input int k, input int mode);
      longint a, b;
      a = poly_x[k];
      b = poly_x[(k + 1) % poly_x.size()];
      case (mode)
         0: return poly_x[k];
         1: return poly_x[k] + $urandom_range(0, 2) - 1;
         2: return 32'((a + b) >>> 1);
         default: return rnd_coord();
      endcase
   endfunction

   function automatic logic signed [31:0] pick_point_y(input int k, input int mode);
      longint a, b;
      a = poly_y[k];
      b = poly_y[(k + 1) % poly_y.size()];
      case (mode)
         0: return poly_y[k];
         1: return poly_y[k] + $urandom_range(0, 2) - 1;
         2: return 32'((a + b) >>> 1);
         default: return rnd_coord();
      endcase
   endfunction

   // closed polygon with random vertices, then a few queries against it
   task automatic polygon_burst();
      int n, k, mode;
      n = $urandom_range(3, 8);
      poly_x.delete();
      poly_y.delete();
      for (int i = 0; i < n; i++) begin
         poly_x = {poly_x, rnd_coord()};
         poly_y = {poly_y, rnd_coord()};
      end
      send(pip_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < n; i++)
         send(pip_pkg::FUNC_APPEND, poly_x[i], poly_y[i], poly_x[(i + 1) % n],
              poly_y[(i + 1) % n]);
      repeat ($urandom_range(2, 6)) begin
         k = $urandom_range(0, n - 1);
         mode = $urandom_range(0, 4);
         send(pip_pkg::FUNC_QUERY, pick_point_x(k, mode), pick_point_y(k, mode),
              $urandom, $urandom);
      end
   endtask

   task automatic random_phase(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0)
            send(2'($urandom_range(0, 3)), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord());
         else
            polygon_burst();
      end
      wait_idle();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cycles = 0;
      items_sent = 0;
      queries_sent = 0;
      calm = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, unused function, 10 by 10 square, extremes
      send(pip_pkg::FUNC_QUERY, 0, 0, 0, 0);
      send(FUNC_SPARE, $urandom, $urandom, $urandom, $urandom);
      send(pip_pkg::FUNC_APPEND, 0, 0, 10 * ONE, 0);
      send(pip_pkg::FUNC_APPEND, 10 * ONE, 0, 10 * ONE, 10 * ONE);
      send(pip_pkg::FUNC_APPEND, 10 * ONE, 10 * ONE, 0, 10 * ONE);
      send(pip_pkg::FUNC_APPEND, 0, 10 * ONE, 0, 0);
      send(pip_pkg::FUNC_QUERY, 5 * ONE, 5 * ONE, 0, 0);
      send(pip_pkg::FUNC_QUERY, 20 * ONE, 5 * ONE, 0, 0);
      send(pip_pkg::FUNC_QUERY, 10 * ONE, 10 * ONE, 0, 0);
      send(pip_pkg::FUNC_QUERY, 5 * ONE, 0, 0, 0);
      send(pip_pkg::FUNC_QUERY, 5 * ONE, 10 * ONE, 0, 0);
      send(pip_pkg::FUNC_QUERY, 32'sh80000000, 5 * ONE, 0, 0);
      send(pip_pkg::FUNC_QUERY, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
      send(pip_pkg::FUNC_APPEND, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
           32'sh7fffffff);
      send(pip_pkg::FUNC_QUERY, 32'sh7fffffff, 32'sh7fffffff, 32'shffffffff,
           32'shffffffff);
      send(pip_pkg::FUNC_QUERY, 32'sh80000000, 32'sh80000000, 0, 0);
      send(pip_pkg::FUNC_QUERY, 32'sh12345678, 32'shedcba987, 0, 0);
      send(pip_pkg::FUNC_CLEAR, 0, 0, 0, 0);
      send(pip_pkg::FUNC_QUERY, 5 * ONE, 5 * ONE, 0, 0);

      // fill the store past its end, then query the last slot
      poly_x.delete();
      poly_y.delete();
      for (int i = 0; i < pip_pkg::MAX_EDGES_DEF + 2; i++) begin
         poly_x = {poly_x, rnd_coord()};
         poly_y = {poly_y, rnd_coord()};
         send(pip_pkg::FUNC_APPEND, poly_x[i], poly_y[i], rnd_coord(), rnd_coord());
      end
      send(pip_pkg::FUNC_QUERY, poly_x[pip_pkg::MAX_EDGES_DEF - 1],
           poly_y[pip_pkg::MAX_EDGES_DEF - 1], 0, 0);
      send(pip_pkg::FUNC_QUERY, rnd_coord(), rnd_coord(), 0, 0);
      send(pip_pkg::FUNC_CLEAR, 0, 0, 0, 0);
      send(pip_pkg::FUNC_QUERY, 0, 0, 0, 0);
      wait_idle();

      random_phase(PHASE_ITEMS);

      set_regs('0, '0, '0, '0);
      random_phase(PHASE_ITEMS);

      set_regs(63'h7fffffff, 63'h7fffffff, 63'h7fffffffffffffff, 63'h7fffffffffffffff);
      random_phase(PHASE_ITEMS / 2);

      set_regs(63'(ONE), 63'(ONE), 63'h1_0000_0000, 63'h100_0000_0000);
      random_phase(PHASE_ITEMS);

      calm = 1;
      set_regs(63'($urandom_range(0, 20 * ONE)), 63'($urandom_range(0, 1000)),
               {31'($urandom_range(0, 255)), $urandom},
               {31'($urandom_range(0, 1023)), $urandom});
      random_phase(PHASE_ITEMS);

      $display("covered %0d transactions, %0d queries answered, five register settings",
               items_sent, answers_seen);
      $display("store overflow, saturated ray start and on-edge hits were exercised");
      if (fail_count == 0)
         $display("** point_in_polygon_test: PASSED **");
      else
         $display("** point_in_polygon_test: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
rtl/pip_pkg.sv
rtl/point_in_polygon_test.sv
bench/point_in_polygon_test_checker.sv
bench/point_in_polygon_test_tb.sv
